// ===== design/etr_pkg.sv =====
`default_nettype none

package etr_pkg;

    // item commands
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_WRITE = 2'd2
    } t_cmd;

    // setup register indexes on the config port
    typedef enum logic [1:0] {
        CFG_VENDOR      = 2'd0,
        CFG_TICK_PERIOD = 2'd1,
        CFG_PER_CAP     = 2'd2,
        CFG_MSG_CAP     = 2'd3
    } t_cfg_idx;

    // decoded register kinds
    typedef enum logic [2:0] {
        REG_CAP   = 3'd0,
        REG_GCFG  = 3'd1,
        REG_ISR   = 3'd2,
        REG_COUNT = 3'd3,
        REG_TCFG  = 3'd4,
        REG_TCMP  = 3'd5,
        REG_ROUTE = 3'd6
    } t_reg;

    localparam int ADDR_W      = 10;
    localparam int DATA_W      = 64;
    localparam int TIMER_IDX_W = 5;

    localparam logic [ADDR_W-1:0] ADDR_CAP      = 10'h000;
    localparam logic [ADDR_W-1:0] ADDR_GCFG     = 10'h010;
    localparam logic [ADDR_W-1:0] ADDR_ISR      = 10'h020;
    localparam logic [ADDR_W-1:0] ADDR_MAIN_CNT = 10'h0F0;
    localparam logic [ADDR_W-1:0] ADDR_TMR      = 10'h100;

    // timer sub-register slots within a 0x20 window
    localparam logic [1:0] SLOT_CFG   = 2'd0;
    localparam logic [1:0] SLOT_CMP   = 2'd1;
    localparam logic [1:0] SLOT_ROUTE = 2'd2;

    // timer config bit positions
    localparam int TC_INT_EN   = 2;
    localparam int TC_PERIODIC = 3;
    localparam int TC_PER_CAP  = 4;
    localparam int TC_SIZE_CAP = 5;
    localparam int TC_VAL_SET  = 6;
    localparam int TC_MODE32   = 8;
    localparam int TC_MSG_EN   = 14;
    localparam int TC_MSG_CAP  = 15;

    // general config bits
    localparam int GC_ENABLE = 0;
    localparam int GC_LEGACY = 1;

    localparam logic [7:0] CAP_REVISION = 8'h01;

    // timers that carry capability bits and drive interrupt lines
    localparam int CAP_TIMERS = 3;

    localparam logic [15:0] VENDOR_RESET = 16'd1;
    localparam logic [26:0] PERIOD_RESET = 27'd69841279;
    localparam logic [2:0]  PER_CAP_RESET = 3'b001;
    localparam logic [2:0]  MSG_CAP_RESET = 3'b000;

    typedef struct packed {
        logic                   err;
        t_reg                   kind;
        logic [TIMER_IDX_W-1:0] timer;
    } t_dec;

    typedef struct packed {
        logic tick;
        logic wr_cfg;
        logic wr_cmp;
        logic wr_route;
        logic rd_cfg;
        logic rd_cmp;
        logic rd_route;
    } t_tmr_ctl;

endpackage

`default_nettype wire

// ===== design/event_timer_register_block.sv =====
// path: input register, then register update and result register, then the master side
// throughput: one beat per cycle while results are taken; both stages move together
//   whenever the result slot frees
// reset: synchronous, active low; clears the counter, status, both stages and per-timer
//   state but sets comparators to all ones; loads setup registers with default values
`default_nettype none

module event_timer_register_block #(
    parameter int NUM_TIMERS = 3
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [1:0] command, [11:2] address, [75:12] write_data, [79:76] zero
    input  wire logic [79:0] s_axis_tdata,

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [63:0] read_data, [66:64] irq_lines, [67] access_error, [71:68] zero
    output logic [71:0]      m_axis_tdata,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int DW = etr_pkg::DATA_W;

    // ------------------------------------------------------------------
    // setup registers (apb)
    // ------------------------------------------------------------------
    logic [15:0] r_vendor;
    logic [26:0] r_tick_period;
    logic [2:0]  r_per_cap;
    logic [2:0]  r_msg_cap;
    logic        w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vendor      <= etr_pkg::VENDOR_RESET;
            r_tick_period <= etr_pkg::PERIOD_RESET;
            r_per_cap     <= etr_pkg::PER_CAP_RESET;
            r_msg_cap     <= etr_pkg::MSG_CAP_RESET;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                etr_pkg::CFG_VENDOR:      r_vendor      <= pwdata[15:0];
                etr_pkg::CFG_TICK_PERIOD: r_tick_period <= pwdata[26:0];
                etr_pkg::CFG_PER_CAP:     r_per_cap     <= pwdata[2:0];
                etr_pkg::CFG_MSG_CAP:     r_msg_cap     <= pwdata[2:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            etr_pkg::CFG_VENDOR:      prdata = {16'd0, r_vendor};
            etr_pkg::CFG_TICK_PERIOD: prdata = {5'd0, r_tick_period};
            etr_pkg::CFG_PER_CAP:     prdata = {29'd0, r_per_cap};
            etr_pkg::CFG_MSG_CAP:     prdata = {29'd0, r_msg_cap};
            default:                  prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // input stage: holds one beat; moves on when the result slot is free
    // ------------------------------------------------------------------
    logic                        r_in_vld;
    logic [1:0]                  r_in_cmd;
    logic [etr_pkg::ADDR_W-1:0]  r_in_addr;
    logic [DW-1:0]               r_in_wdata;
    logic                        r_out_vld;
    logic                        w_adv;

    // the beat in the input stage is processed in the cycle it advances
    assign w_adv         = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_cmd   <= s_axis_tdata[1:0];
            r_in_addr  <= s_axis_tdata[11:2];
            r_in_wdata <= s_axis_tdata[75:12];
        end
    end

    // ------------------------------------------------------------------
    // decode and global state
    // ------------------------------------------------------------------
    etr_pkg::t_dec w_dec;

    etr_decode #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_decode (
        .i_addr (r_in_addr),
        .o_dec  (w_dec)
    );

    logic                  w_is_tick, w_is_rd, w_is_wr;
    logic                  w_acc_ok, w_wr_ok, w_tick_adv;
    logic [DW-1:0]         w_count_next;

    logic [DW-1:0]         r_count, n_count;
    logic                  r_cnt_en, n_cnt_en;
    logic                  r_legacy, n_legacy;
    logic [NUM_TIMERS-1:0] r_status, n_status;

    assign w_is_tick  = (r_in_cmd == etr_pkg::CMD_TICK);
    assign w_is_rd    = (r_in_cmd == etr_pkg::CMD_READ);
    assign w_is_wr    = (r_in_cmd == etr_pkg::CMD_WRITE);
    assign w_acc_ok   = (w_is_rd || w_is_wr) && !w_dec.err;
    assign w_wr_ok    = w_adv && w_is_wr && !w_dec.err;
    // a tick only counts while the counter is enabled
    assign w_tick_adv = w_adv && w_is_tick && r_cnt_en;
    assign w_count_next = r_count + DW'(1);

    // ------------------------------------------------------------------
    // timer cells, one per comparator
    // ------------------------------------------------------------------
    etr_pkg::t_tmr_ctl     w_tctl [NUM_TIMERS];
    logic [DW-1:0]         w_trd  [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] w_set_irq;
    logic [NUM_TIMERS-1:0] w_int_en_nxt;

    for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_tmr
        logic w_hit;
        logic w_per_cap;
        logic w_msg_cap;

        assign w_hit = w_acc_ok && (w_dec.timer == (etr_pkg::TIMER_IDX_W)'(g));

        // only the first few timers carry capability bits
        if (g < etr_pkg::CAP_TIMERS) begin : g_cap
            assign w_per_cap = r_per_cap[g];
            assign w_msg_cap = r_msg_cap[g];
        end else begin : g_nocap
            assign w_per_cap = 1'b0;
            assign w_msg_cap = 1'b0;
        end

        assign w_tctl[g].tick     = w_tick_adv;
        assign w_tctl[g].wr_cfg   = w_adv && w_is_wr && w_hit
                                    && (w_dec.kind == etr_pkg::REG_TCFG);
        assign w_tctl[g].wr_cmp   = w_adv && w_is_wr && w_hit
                                    && (w_dec.kind == etr_pkg::REG_TCMP);
        assign w_tctl[g].wr_route = w_adv && w_is_wr && w_hit
                                    && (w_dec.kind == etr_pkg::REG_ROUTE);
        assign w_tctl[g].rd_cfg   = w_is_rd && w_hit && (w_dec.kind == etr_pkg::REG_TCFG);
        assign w_tctl[g].rd_cmp   = w_is_rd && w_hit && (w_dec.kind == etr_pkg::REG_TCMP);
        assign w_tctl[g].rd_route = w_is_rd && w_hit && (w_dec.kind == etr_pkg::REG_ROUTE);

        etr_timer u_timer (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_tctl[g]),
            .i_wdata      (r_in_wdata),
            .i_count_next (w_count_next),
            .i_per_cap    (w_per_cap),
            .i_msg_cap    (w_msg_cap),
            .o_set_irq    (w_set_irq[g]),
            .o_int_en_nxt (w_int_en_nxt[g]),
            .o_rdata      (w_trd[g])
        );
    end

    // ------------------------------------------------------------------
    // global register updates
    // ------------------------------------------------------------------
    always_comb begin
        n_count  = r_count;
        n_cnt_en = r_cnt_en;
        n_legacy = r_legacy;
        n_status = r_status;
        if (w_tick_adv) begin
            n_count  = w_count_next;
            n_status = r_status | w_set_irq;
        end
        if (w_wr_ok) begin
            case (w_dec.kind)
                etr_pkg::REG_GCFG: begin
                    n_cnt_en = r_in_wdata[etr_pkg::GC_ENABLE];
                    n_legacy = r_in_wdata[etr_pkg::GC_LEGACY];
                end
                // write one to clear
                etr_pkg::REG_ISR: n_status = r_status & ~r_in_wdata[NUM_TIMERS-1:0];
                // counter is writable only while halted
                etr_pkg::REG_COUNT: begin
                    if (!r_cnt_en) begin
                        n_count = r_in_wdata;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_cnt_en <= 1'b0;
            r_legacy <= 1'b0;
            r_status <= '0;
        end else begin
            r_count  <= n_count;
            r_cnt_en <= n_cnt_en;
            r_legacy <= n_legacy;
            r_status <= n_status;
        end
    end

    // ------------------------------------------------------------------
    // read data selection (state before this beat's update)
    // ------------------------------------------------------------------
    logic [DW-1:0] w_cap;
    logic [DW-1:0] w_tmr_rd;
    logic [DW-1:0] w_rdata;

    assign w_cap = {5'd0, r_tick_period, r_vendor, 1'b0, 1'b0, 1'b1,
                    5'(NUM_TIMERS - 1), etr_pkg::CAP_REVISION};

    always_comb begin
        w_tmr_rd = '0;
        for (int t = 0; t < NUM_TIMERS; t++) begin
            w_tmr_rd = w_tmr_rd | w_trd[t];
        end
    end

    always_comb begin
        w_rdata = '0;
        if (w_is_rd && !w_dec.err) begin
            case (w_dec.kind)
                etr_pkg::REG_CAP:   w_rdata = w_cap;
                etr_pkg::REG_GCFG:  w_rdata = {62'd0, r_legacy, r_cnt_en};
                etr_pkg::REG_ISR:   w_rdata = DW'(r_status);
                etr_pkg::REG_COUNT: w_rdata = r_count;
                default:            w_rdata = w_tmr_rd;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    logic [DW-1:0] r_out_rdata;
    logic [2:0]    r_out_irq;
    logic          r_out_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    // interrupt lines reflect status and enables after this beat
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_rdata <= w_rdata;
            r_out_irq   <= n_status[2:0] & w_int_en_nxt[2:0];
            r_out_err   <= (w_is_rd || w_is_wr) && w_dec.err;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {4'd0, r_out_err, r_out_irq, r_out_rdata};

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_count_locked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr_ok && (w_dec.kind == etr_pkg::REG_COUNT) && r_cnt_en)
        |=> (r_count == $past(r_count)))
        else $error("counter written while running");

    a_halted_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_is_tick && !r_cnt_en) |=> $stable(r_count))
        else $error("halted counter advanced");

    a_status_set_by_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_tick_adv) |=> ((r_status & ~$past(r_status)) == '0))
        else $error("status bit set without a counting tick");

    a_err_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_err) |-> (r_out_rdata == '0))
        else $error("errored beat carries read data");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && r_out_vld && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while both stages are stalled");

endmodule

`default_nettype wire

// ===== design/etr_decode.sv =====
`default_nettype none

module etr_decode #(
    parameter int NUM_TIMERS = 3
) (
    input  wire logic [etr_pkg::ADDR_W-1:0] i_addr,
    output etr_pkg::t_dec                   o_dec
);

    logic [etr_pkg::ADDR_W-1:0]      w_off;
    logic [etr_pkg::TIMER_IDX_W-1:0] w_tt;
    logic [1:0]                      w_slot;

    assign w_off  = i_addr - etr_pkg::ADDR_TMR;
    assign w_tt   = w_off[etr_pkg::ADDR_W-1:5];
    assign w_slot = w_off[4:3];

    always_comb begin
        o_dec.err   = 1'b0;
        o_dec.kind  = etr_pkg::REG_CAP;
        o_dec.timer = w_tt;
        if (i_addr[2:0] != 3'd0) begin
            o_dec.err = 1'b1;
        end else if (i_addr < etr_pkg::ADDR_TMR) begin
            case (i_addr)
                etr_pkg::ADDR_CAP:      o_dec.kind = etr_pkg::REG_CAP;
                etr_pkg::ADDR_GCFG:     o_dec.kind = etr_pkg::REG_GCFG;
                etr_pkg::ADDR_ISR:      o_dec.kind = etr_pkg::REG_ISR;
                etr_pkg::ADDR_MAIN_CNT: o_dec.kind = etr_pkg::REG_COUNT;
                default:                o_dec.err  = 1'b1;
            endcase
        end else begin
            // beyond the last timer or in the unused fourth slot
            if ({1'b0, w_tt} >= (etr_pkg::TIMER_IDX_W + 1)'(NUM_TIMERS)) begin
                o_dec.err = 1'b1;
            end
            case (w_slot)
                etr_pkg::SLOT_CFG:   o_dec.kind = etr_pkg::REG_TCFG;
                etr_pkg::SLOT_CMP:   o_dec.kind = etr_pkg::REG_TCMP;
                etr_pkg::SLOT_ROUTE: o_dec.kind = etr_pkg::REG_ROUTE;
                default:             o_dec.err  = 1'b1;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== design/etr_timer.sv =====
`default_nettype none

module etr_timer (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire etr_pkg::t_tmr_ctl          i_ctl,
    input  wire logic [etr_pkg::DATA_W-1:0] i_wdata,
    input  wire logic [etr_pkg::DATA_W-1:0] i_count_next,
    input  wire logic                       i_per_cap,
    input  wire logic                       i_msg_cap,
    output logic                            o_set_irq,
    output logic                            o_int_en_nxt,
    output logic [etr_pkg::DATA_W-1:0]      o_rdata
);

    logic                       r_int_en, n_int_en;
    logic                       r_periodic, n_periodic;
    logic                       r_val_set, n_val_set;
    logic                       r_mode32, n_mode32;
    logic                       r_msg_en, n_msg_en;
    logic [etr_pkg::DATA_W-1:0] r_cmp, n_cmp;
    logic [etr_pkg::DATA_W-1:0] r_period, n_period;
    logic [etr_pkg::DATA_W-1:0] r_route, n_route;
    logic                       w_match;
    logic [etr_pkg::DATA_W-1:0] w_cfg_rd;

    assign w_match   = i_ctl.tick && (r_cmp == i_count_next);
    assign o_set_irq = w_match && r_int_en;

    always_comb begin
        n_int_en   = r_int_en;
        n_periodic = r_periodic;
        n_val_set  = r_val_set;
        n_mode32   = r_mode32;
        n_msg_en   = r_msg_en;
        n_cmp      = r_cmp;
        n_period   = r_period;
        n_route    = r_route;
        if (i_ctl.wr_cfg) begin
            n_int_en   = i_wdata[etr_pkg::TC_INT_EN];
            n_periodic = i_wdata[etr_pkg::TC_PERIODIC] && i_per_cap;
            n_val_set  = i_wdata[etr_pkg::TC_VAL_SET];
            n_mode32   = i_wdata[etr_pkg::TC_MODE32];
            n_msg_en   = i_wdata[etr_pkg::TC_MSG_EN] && i_msg_cap;
        end
        if (i_ctl.wr_cmp) begin
            if (r_periodic) begin
                n_period = i_wdata;
                if (r_val_set) begin
                    n_cmp = i_wdata;
                end
            end else begin
                n_cmp = i_wdata;
            end
            n_val_set = 1'b0;
        end
        if (i_ctl.wr_route) begin
            n_route = i_wdata;
        end
        // periodic reload on match, interrupt enabled or not
        if (w_match && r_periodic) begin
            n_cmp = r_cmp + r_period;
        end
    end

    assign o_int_en_nxt = n_int_en;

    always_comb begin
        w_cfg_rd                         = '0;
        w_cfg_rd[etr_pkg::TC_INT_EN]     = r_int_en;
        w_cfg_rd[etr_pkg::TC_PERIODIC]   = r_periodic;
        w_cfg_rd[etr_pkg::TC_PER_CAP]    = i_per_cap;
        w_cfg_rd[etr_pkg::TC_SIZE_CAP]   = 1'b1;
        w_cfg_rd[etr_pkg::TC_VAL_SET]    = r_val_set;
        w_cfg_rd[etr_pkg::TC_MODE32]     = r_mode32;
        w_cfg_rd[etr_pkg::TC_MSG_EN]     = r_msg_en;
        w_cfg_rd[etr_pkg::TC_MSG_CAP]    = i_msg_cap;
    end

    always_comb begin
        o_rdata = '0;
        if (i_ctl.rd_cfg) begin
            o_rdata = w_cfg_rd;
        end else if (i_ctl.rd_cmp) begin
            o_rdata = r_cmp;
        end else if (i_ctl.rd_route) begin
            o_rdata = r_route;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int_en   <= 1'b0;
            r_periodic <= 1'b0;
            r_val_set  <= 1'b0;
            r_mode32   <= 1'b0;
            r_msg_en   <= 1'b0;
            r_cmp      <= '1;
            r_period   <= '0;
            r_route    <= '0;
        end else begin
            r_int_en   <= n_int_en;
            r_periodic <= n_periodic;
            r_val_set  <= n_val_set;
            r_mode32   <= n_mode32;
            r_msg_en   <= n_msg_en;
            r_cmp      <= n_cmp;
            r_period   <= n_period;
            r_route    <= n_route;
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/event_timer_register_block_test.sv =====
`default_nettype none

module event_timer_register_block_test;

    localparam int NUM_TMR      = 3;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 4;     // two-stage pipe plus margin
    localparam int HOLD_SPAN    = 60;    // long receiver hold-off, in cycles

    // command value the block must treat as a no-op
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // packed timer mode, as the block keeps it per timer
    typedef struct packed {
        logic msg_en;
        logic mode32;
        logic val_set;
        logic periodic;
        logic int_en;
    } t_timer_mode;

    // one result beat: read data, interrupt lines, access error
    typedef struct packed {
        logic        access_error;
        logic [2:0]  irq_lines;
        logic [63:0] read_data;
    } t_timer_reply;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [1:0] command, [11:2] address, [75:12] write_data, [79:76] zero
    logic [79:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [63:0] read_data, [66:64] irq_lines, [67] access_error, [71:68] zero
    logic [71:0] m_axis_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    event_timer_register_block #(
        .NUM_TIMERS(NUM_TMR)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // run guard
    int cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // timer state mirror, kept in step with every accepted input beat
    // ------------------------------------------------------------------
    logic [15:0]  set_vendor  = etr_pkg::VENDOR_RESET;
    logic [26:0]  set_tick_fs = etr_pkg::PERIOD_RESET;
    logic [2:0]   set_per_cap = etr_pkg::PER_CAP_RESET;
    logic [2:0]   set_msg_cap = etr_pkg::MSG_CAP_RESET;

    logic [63:0]  main_cnt  = '0;
    logic         cnt_run   = 1'b0;
    logic         legacy_rt = 1'b0;
    logic [2:0]   irq_stat  = '0;
    t_timer_mode  tmode      [NUM_TMR] = '{default: '0};
    logic [63:0]  cmp_val    [NUM_TMR] = '{default: '1};
    logic [63:0]  period_val [NUM_TMR] = '{default: '0};
    logic [63:0]  route_val  [NUM_TMR] = '{default: '0};

    t_timer_reply replies_due[$];
    int           mismatch_count = 0;

    function automatic logic [9:0] timer_reg_addr(int unsigned t, logic [1:0] slot);
        return etr_pkg::ADDR_TMR + 10'(t << 5) + 10'({slot, 3'b000});
    endfunction

    // applies one item to the mirror and returns the beat the block must send
    function automatic t_timer_reply apply_timer_item(logic [1:0] cmd, logic [9:0] addr,
                                                      logic [63:0] data);
        t_timer_reply r;
        logic [9:0]   off;
        int unsigned  t;
        logic [1:0]   slot;
        logic         wr;
        r = '0;
        wr = (cmd == etr_pkg::CMD_WRITE);
        if (cmd == etr_pkg::CMD_TICK) begin
            // halted counter ignores ticks; match is against the new count
            if (cnt_run) begin
                main_cnt = main_cnt + 64'd1;
                for (int i = 0; i < NUM_TMR; i++) begin
                    if (cmp_val[i] == main_cnt) begin
                        if (tmode[i].int_en)
                            irq_stat[i] = 1'b1;
                        if (tmode[i].periodic)
                            cmp_val[i] = cmp_val[i] + period_val[i];
                    end
                end
            end
        end else if (cmd == etr_pkg::CMD_READ || cmd == etr_pkg::CMD_WRITE) begin
            if (addr[2:0] != 3'd0) begin
                r.access_error = 1'b1;
            end else if (addr < etr_pkg::ADDR_TMR) begin
                case (addr)
                    etr_pkg::ADDR_CAP: begin
                        // read only, writes dropped silently
                        r.read_data = {5'd0, set_tick_fs, set_vendor, 3'b001,
                                       5'(NUM_TMR - 1), etr_pkg::CAP_REVISION};
                    end
                    etr_pkg::ADDR_GCFG: begin
                        if (wr) begin
                            cnt_run   = data[etr_pkg::GC_ENABLE];
                            legacy_rt = data[etr_pkg::GC_LEGACY];
                        end else begin
                            r.read_data = {62'd0, legacy_rt, cnt_run};
                        end
                    end
                    etr_pkg::ADDR_ISR: begin
                        if (wr)
                            irq_stat = irq_stat & ~data[2:0];
                        else
                            r.read_data = {61'd0, irq_stat};
                    end
                    etr_pkg::ADDR_MAIN_CNT: begin
                        // counter only loads while halted
                        if (wr) begin
                            if (!cnt_run)
                                main_cnt = data;
                        end else begin
                            r.read_data = main_cnt;
                        end
                    end
                    default: r.access_error = 1'b1;
                endcase
            end else begin
                off  = addr - etr_pkg::ADDR_TMR;
                t    = {27'd0, off[9:5]};
                slot = off[4:3];
                if (t >= NUM_TMR || slot == 2'd3) begin
                    r.access_error = 1'b1;
                end else begin
                    case (slot)
                        etr_pkg::SLOT_CFG: begin
                            if (wr) begin
                                tmode[t].int_en   = data[etr_pkg::TC_INT_EN];
                                tmode[t].periodic = data[etr_pkg::TC_PERIODIC]
                                                    & set_per_cap[t];
                                tmode[t].val_set  = data[etr_pkg::TC_VAL_SET];
                                tmode[t].mode32   = data[etr_pkg::TC_MODE32];
                                tmode[t].msg_en   = data[etr_pkg::TC_MSG_EN]
                                                    & set_msg_cap[t];
                            end else begin
                                r.read_data[etr_pkg::TC_SIZE_CAP] = 1'b1;
                                r.read_data[etr_pkg::TC_INT_EN]   = tmode[t].int_en;
                                r.read_data[etr_pkg::TC_PERIODIC] = tmode[t].periodic;
                                r.read_data[etr_pkg::TC_VAL_SET]  = tmode[t].val_set;
                                r.read_data[etr_pkg::TC_MODE32]   = tmode[t].mode32;
                                r.read_data[etr_pkg::TC_MSG_EN]   = tmode[t].msg_en;
                                r.read_data[etr_pkg::TC_PER_CAP]  = set_per_cap[t];
                                r.read_data[etr_pkg::TC_MSG_CAP]  = set_msg_cap[t];
                            end
                        end
                        etr_pkg::SLOT_CMP: begin
                            // periodic: always the period, comparator only when
                            // value-set is pending; one-shot: the comparator
                            if (wr) begin
                                if (tmode[t].periodic) begin
                                    period_val[t] = data;
                                    if (tmode[t].val_set)
                                        cmp_val[t] = data;
                                end else begin
                                    cmp_val[t] = data;
                                end
                                tmode[t].val_set = 1'b0;
                            end else begin
                                r.read_data = cmp_val[t];
                            end
                        end
                        default: begin
                            if (wr)
                                route_val[t] = data;
                            else
                                r.read_data = route_val[t];
                        end
                    endcase
                end
            end
            if (wr)
                r.read_data = '0;
        end
        r.irq_lines = irq_stat & {tmode[2].int_en, tmode[1].int_en, tmode[0].int_en};
        return r;
    endfunction

    // ------------------------------------------------------------------
    // receiver: random stalls plus an on-demand long hold-off
    // ------------------------------------------------------------------
    int unsigned rx_stall_pct = 0;
    int unsigned hold_req = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;

    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_SPAN;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // result beats against the oldest pending reply
    always @(posedge i_clk) begin
        t_timer_reply want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (replies_due.size() == 0) begin
                $display("%0t: result beat with nothing pending, expected none got %h",
                         $time, m_axis_tdata);
                mismatch_count++;
            end else begin
                want = replies_due.pop_front();
                if (m_axis_tdata[63:0] !== want.read_data) begin
                    $display("%0t: read_data expected %h got %h",
                             $time, want.read_data, m_axis_tdata[63:0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[66:64] !== want.irq_lines) begin
                    $display("%0t: irq_lines expected %b got %b",
                             $time, want.irq_lines, m_axis_tdata[66:64]);
                    mismatch_count++;
                end
                if (m_axis_tdata[67] !== want.access_error) begin
                    $display("%0t: access_error expected %b got %b",
                             $time, want.access_error, m_axis_tdata[67]);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------
    int unsigned tx_idle_pct = 0;

    // tvalid stays high on return so the next beat can follow back to back
    task automatic send_timer_item(input logic [1:0] cmd, input logic [9:0] addr,
                                   input logic [63:0] data);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, data, addr, cmd};
        do @(posedge i_clk); while (!s_axis_tready);
        replies_due.push_back(apply_timer_item(cmd, addr, data));
    endtask

    task automatic wait_for_replies();
        s_axis_tvalid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // setup port write: setup beat then access beat
    task automatic write_setup_reg(input etr_pkg::t_cfg_idx idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            etr_pkg::CFG_VENDOR:      set_vendor  = value[15:0];
            etr_pkg::CFG_TICK_PERIOD: set_tick_fs = value[26:0];
            etr_pkg::CFG_PER_CAP:     set_per_cap = value[2:0];
            default:                  set_msg_cap = value[2:0];
        endcase
        @(posedge i_clk);
    endtask

    task automatic load_setup(input logic [31:0] vendor, input logic [31:0] tick_fs,
                              input logic [31:0] per_cap, input logic [31:0] msg_cap);
        write_setup_reg(etr_pkg::CFG_VENDOR, vendor);
        write_setup_reg(etr_pkg::CFG_TICK_PERIOD, tick_fs);
        write_setup_reg(etr_pkg::CFG_PER_CAP, per_cap);
        write_setup_reg(etr_pkg::CFG_MSG_CAP, msg_cap);
    endtask

    // mostly well-formed accesses steered toward comparator matches, some noise
    task automatic pick_timer_item(output logic [1:0] cmd, output logic [9:0] addr,
                                   output logic [63:0] data);
        int unsigned roll;
        int unsigned t;
        logic [9:0]  targets [7];
        roll = $urandom_range(99);
        t    = $urandom_range(NUM_TMR - 1);
        targets = '{etr_pkg::ADDR_CAP, etr_pkg::ADDR_GCFG, etr_pkg::ADDR_ISR,
                    etr_pkg::ADDR_MAIN_CNT, timer_reg_addr(t, etr_pkg::SLOT_CFG),
                    timer_reg_addr(t, etr_pkg::SLOT_CMP),
                    timer_reg_addr(t, etr_pkg::SLOT_ROUTE)};
        addr = targets[$urandom_range(6)];
        data = {$urandom, $urandom};
        if (roll < 35) begin
            cmd = etr_pkg::CMD_TICK;
        end else if (roll < 50) begin
            cmd = etr_pkg::CMD_READ;
        end else if (roll < 88) begin
            cmd = etr_pkg::CMD_WRITE;
            if (addr == etr_pkg::ADDR_GCFG) begin
                data[etr_pkg::GC_ENABLE] = ($urandom_range(9) != 0);
            end else if (addr == etr_pkg::ADDR_MAIN_CNT) begin
                case ($urandom_range(2))
                    0:       ;
                    1:       data = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(8));
                    default: data = cmp_val[t] - 64'($urandom_range(1, 6));
                endcase
            end else if (addr == timer_reg_addr(t, etr_pkg::SLOT_CMP)) begin
                // short periods keep periodic timers firing
                if (tmode[t].periodic && !tmode[t].val_set)
                    data = 64'($urandom_range(4));
                else if ($urandom_range(3) != 0)
                    data = main_cnt + 64'($urandom_range(1, 8));
            end
        end else begin
            cmd  = 2'($urandom_range(3));
            addr = 10'($urandom_range(1023));
        end
    endtask

    task automatic run_random_phase(input int unsigned n_items, input int unsigned tx_pct,
                                    input int unsigned rx_pct);
        logic [1:0]  cmd;
        logic [9:0]  addr;
        logic [63:0] data;
        tx_idle_pct = tx_pct;
        rx_stall_pct <= rx_pct;
        for (int k = 0; k < n_items; k++) begin
            pick_timer_item(cmd, addr, data);
            send_timer_item(cmd, addr, data);
            // sender pauses now and then until the pipe is empty
            if (k % 97 == 96)
                wait_for_replies();
        end
        wait_for_replies();
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_reset_state();
        send_timer_item(etr_pkg::CMD_READ, etr_pkg::ADDR_CAP, '0);
        send_timer_item(etr_pkg::CMD_READ, timer_reg_addr(2, etr_pkg::SLOT_CFG), '0);
        send_timer_item(etr_pkg::CMD_READ, timer_reg_addr(2, etr_pkg::SLOT_CMP), '0);
        wait_for_replies();
    endtask

    task automatic test_bad_access();
        // unaligned, then a reserved hole
        send_timer_item(etr_pkg::CMD_READ, 10'h004, '1);
        send_timer_item(etr_pkg::CMD_READ, 10'h008, '0);
        // past the last timer, then the unused slot
        send_timer_item(etr_pkg::CMD_WRITE, timer_reg_addr(3, etr_pkg::SLOT_CFG), '1);
        send_timer_item(etr_pkg::CMD_WRITE, etr_pkg::ADDR_TMR + 10'h018, '1);
        // no-op command
        send_timer_item(CMD_UNUSED, 10'h3FF, '1);
        // read-only, no error
        send_timer_item(etr_pkg::CMD_WRITE, etr_pkg::ADDR_CAP, '1);
        wait_for_replies();
    endtask

    task automatic test_count_and_match();
        logic [63:0] per_cfg;
        per_cfg = (64'd1 << etr_pkg::TC_INT_EN) | (64'd1 << etr_pkg::TC_PERIODIC)
                  | (64'd1 << etr_pkg::TC_VAL_SET);
        // halted: counter loads, just below wrap
        send_timer_item(etr_pkg::CMD_WRITE, etr_pkg::ADDR_MAIN_CNT, 64'hFFFF_FFFF_FFFF_FFFD);
        // timer 0 periodic with value-set, comparator at all ones, then period 2
        send_timer_item(etr_pkg::CMD_WRITE, timer_reg_addr(0, etr_pkg::SLOT_CFG), per_cfg);
        send_timer_item(etr_pkg::CMD_WRITE, timer_reg_addr(0, etr_pkg::SLOT_CMP), '1);
        send_timer_item(etr_pkg::CMD_WRITE, timer_reg_addr(0, etr_pkg::SLOT_CMP), 64'd2);
        // timer 1 lacks periodic and message capability: only int enable and value-set stick
        send_timer_item(etr_pkg::CMD_WRITE, timer_reg_addr(1, etr_pkg::SLOT_CFG),
                        per_cfg | (64'd1 << etr_pkg::TC_MSG_EN));
        send_timer_item(etr_pkg::CMD_WRITE, timer_reg_addr(1, etr_pkg::SLOT_CMP), 64'd0);
        send_timer_item(etr_pkg::CMD_WRITE, etr_pkg::ADDR_GCFG, 64'd3);
        // running: counter write dropped
        send_timer_item(etr_pkg::CMD_WRITE, etr_pkg::ADDR_MAIN_CNT, 64'd0);
        // through the wrap, both timers fire, timer 0 twice
        repeat (4) send_timer_item(etr_pkg::CMD_TICK, '0, '0);
        send_timer_item(etr_pkg::CMD_READ, etr_pkg::ADDR_ISR, '0);
        send_timer_item(etr_pkg::CMD_WRITE, etr_pkg::ADDR_ISR, 64'd1);
        send_timer_item(etr_pkg::CMD_WRITE, etr_pkg::ADDR_GCFG, 64'd0);
        send_timer_item(etr_pkg::CMD_TICK, '1, '1);
        send_timer_item(etr_pkg::CMD_READ, etr_pkg::ADDR_MAIN_CNT, '0);
        wait_for_replies();
    endtask

    task automatic test_backpressure();
        logic [1:0]  cmd;
        logic [9:0]  addr;
        logic [63:0] data;
        tx_idle_pct = 0;
        rx_stall_pct <= 0;
        hold_req <= hold_req + 1;
        // sender keeps offering through the hold, so the input side stalls
        repeat (30) begin
            pick_timer_item(cmd, addr, data);
            send_timer_item(cmd, addr, data);
        end
        wait_for_replies();
    endtask

    task automatic test_random_traffic();
        load_setup(32'd1, 32'd5, 32'd0, 32'd0);
        run_random_phase(150, 0, 0);
        load_setup(32'd65535, 32'd100000000, 32'd7, 32'd7);
        run_random_phase(150, 48, 0);
        load_setup($urandom_range(1, 65535), $urandom_range(5, 100000000),
                   $urandom_range(7), $urandom_range(7));
        run_random_phase(150, 0, 48);
        load_setup($urandom_range(1, 65535), $urandom_range(5, 100000000),
                   $urandom_range(7), $urandom_range(7));
        run_random_phase(150, 32, 32);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_bad_access();
        test_count_and_match();
        test_backpressure();
        test_random_traffic();
        wait_for_replies();
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
